@@ hdl/lkvc_pkg.sv @@
// Package for the LRU key/value cache: sizes, operation codes and shared types.
// Used by the request channel interface, the top level, the checker and the testbench; depends on nothing.
`default_nettype none
package lkvc_pkg;
   localparam int ENTRIES_DEF = 64;
   localparam logic [15:0] PAYLOAD_SIZE_RST = 16'd1952;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_EVICT  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] key_hi;
      logic [63:0] key_mid;
      logic [63:0] key_lo;
      logic [63:0] value_in;
      logic [15:0] value_length;
   } req_type;
endpackage
`default_nettype wire

@@ hdl/lkvc_req_if.sv @@
// Request channel interface: valid/ready handshake with the request payload.
// Depends on lkvc_pkg.
`default_nettype none
interface lkvc_req_if import lkvc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] key_hi;
   logic [63:0] key_mid;
   logic [63:0] key_lo;
   logic [63:0] value_in;
   logic [15:0] value_length;
   modport source (output valid, kind, key_hi, key_mid, key_lo, value_in, value_length,
                   input ready);
   modport sink (input valid, kind, key_hi, key_mid, key_lo, value_in, value_length,
                 output ready);
endinterface
`default_nettype wire

@@ hdl/lkvc_rsp_if.sv @@
// Response channel interface: valid/ready handshake with the response payload.
// Depends on nothing.
`default_nettype none
interface lkvc_rsp_if #(parameter int CountWidth = 7) ();
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [63:0]           value_out;
   logic [CountWidth-1:0] entries_used;
   modport source (output valid, found, value_out, entries_used, input ready);
   modport sink (input valid, found, value_out, entries_used, output ready);
endinterface
`default_nettype wire

@@ hdl/lru_key_value_cache.sv @@
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg, lkvc_req_if and lkvc_rsp_if.
//
// One request is handled at a time. The sequencer walks the tag, payload and
// rank memories one entry per cycle. A search pass finds the key, or the free
// slot and the least recent entry. An update pass then rewrites the ranks.
// Each pass reads through the single read port per store, with registered
// read data. A lookup or evict miss or an ignored insert is answered
// after the search, an evict hit after the update pass, and a lookup hit
// or an insert after it and a final write of the target entry. A clear skips
// the search. The next request can be taken in the cycle after the response
// is taken. Valid marks are flip-flops, so no clearing pass follows reset.
`default_nettype none
module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_we,
   input  wire logic [15:0] csr_wdata,
   lkvc_req_if.sink   req,
   lkvc_rsp_if.source rsp
);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   // Kinds of rank update pass.
   localparam logic [1:0] MODE_TOUCH = 2'd0;
   localparam logic [1:0] MODE_AGE   = 2'd1;
   localparam logic [1:0] MODE_EVICT = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_DEC  = 6'b000100,
      ST_UPD  = 6'b001000,
      ST_WR   = 6'b010000,
      ST_RSP  = 6'b100000
   } state_type;

   logic [31:0] tag_hi_mem [ENTRIES];
   logic [63:0] tag_mid_mem [ENTRIES];
   logic [63:0] tag_lo_mem [ENTRIES];
   logic [63:0] pay_mem [ENTRIES];
   logic [IW-1:0] rank_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   state_type state_ff;
   req_type   req_ff;
   logic [15:0] psize_ff;
   logic [CW-1:0] count_ff;
   logic [IW:0] idx_ff;       // read address of the sweep
   logic [IW-1:0] rd_idx_ff;  // address of the registered read data
   logic        rd_vld_ff;
   logic [31:0] rd_hi_ff;
   logic [63:0] rd_mid_ff, rd_lo_ff, rd_pay_ff;
   logic [IW-1:0] rd_rank_ff;
   logic        hit_ff, free_ok_ff, old_ok_ff;
   logic [IW-1:0] hit_idx_ff, free_ff, old_ff, tgt_ff;
   logic [IW-1:0] hrank_ff;
   logic [63:0] hpay_ff;
   logic        found_ff;
   logic [63:0] vout_ff;
   logic [1:0]  mode_ff;
   logic [IW-1:0] rref_ff;

   wire logic zero_key = (req_ff.key_hi == '0) && (req_ff.key_mid == '0) &&
                         (req_ff.key_lo == '0);
   wire logic match = rd_vld_ff && valid_ff[rd_idx_ff] && rd_hi_ff == req_ff.key_hi &&
                      rd_mid_ff == req_ff.key_mid && rd_lo_ff == req_ff.key_lo;
   wire logic last_rd = (idx_ff == ENTRIES[IW:0]);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_RSP);
   assign rsp.found = found_ff;
   assign rsp.value_out = vout_ff;
   assign rsp.entries_used = count_ff;

   // Memory reads, one entry per cycle.
   always_ff @(posedge clock) begin
      rd_hi_ff   <= tag_hi_mem[idx_ff[IW-1:0]];
      rd_mid_ff  <= tag_mid_mem[idx_ff[IW-1:0]];
      rd_lo_ff   <= tag_lo_mem[idx_ff[IW-1:0]];
      rd_pay_ff  <= pay_mem[idx_ff[IW-1:0]];
      rd_rank_ff <= rank_mem[idx_ff[IW-1:0]];
      rd_idx_ff  <= idx_ff[IW-1:0];
   end

   // Rank writes: the update pass rewrites the entry in the read register.
   logic          rk_we;
   logic [IW-1:0] rk_wa, rk_wd;
   always_comb begin
      rk_we = 1'b0;
      rk_wa = rd_idx_ff;
      rk_wd = rd_rank_ff;
      if (state_ff == ST_UPD && rd_vld_ff && valid_ff[rd_idx_ff]) begin
         case (mode_ff)
            MODE_TOUCH: if (rd_rank_ff < rref_ff) begin
               rk_we = 1'b1; rk_wd = rd_rank_ff + 1'b1;
            end
            MODE_AGE: begin
               rk_we = 1'b1; rk_wd = rd_rank_ff + 1'b1;
            end
            MODE_EVICT: if (rd_rank_ff > rref_ff) begin
               rk_we = 1'b1; rk_wd = rd_rank_ff - 1'b1;
            end
            default: ;
         endcase
      end else if (state_ff == ST_WR) begin
         rk_we = 1'b1; rk_wa = tgt_ff; rk_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rk_we) rank_mem[rk_wa] <= rk_wd;
      if (state_ff == ST_WR && mode_ff == MODE_AGE) begin
         tag_hi_mem[tgt_ff]  <= req_ff.key_hi;
         tag_mid_mem[tgt_ff] <= req_ff.key_mid;
         tag_lo_mem[tgt_ff]  <= req_ff.key_lo;
         pay_mem[tgt_ff]     <= req_ff.value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         psize_ff <= PAYLOAD_SIZE_RST;
         idx_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (csr_we) psize_ff <= csr_wdata;
         case (state_ff)
            ST_IDLE: if (req.valid) begin
               req_ff <= '{req.kind, req.key_hi, req.key_mid, req.key_lo,
                           req.value_in, req.value_length};
               idx_ff <= '0;
               rd_vld_ff <= 1'b0;
               hit_ff <= 1'b0; free_ok_ff <= 1'b0; old_ok_ff <= 1'b0;
               found_ff <= 1'b0; vout_ff <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (op_type'(req_ff.kind) == OP_CLEAR) begin
                  valid_ff <= '0;
                  count_ff <= '0;
                  state_ff <= ST_RSP;
               end else begin
                  if (!last_rd) idx_ff <= idx_ff + 1'b1;
                  rd_vld_ff <= !last_rd;
                  if (match && !hit_ff) begin
                     hit_ff <= 1'b1; hit_idx_ff <= rd_idx_ff;
                     hrank_ff <= rd_rank_ff; hpay_ff <= rd_pay_ff;
                  end
                  if (rd_vld_ff && !valid_ff[rd_idx_ff] && !free_ok_ff) begin
                     free_ok_ff <= 1'b1; free_ff <= rd_idx_ff;
                  end
                  if (rd_vld_ff && valid_ff[rd_idx_ff] && !old_ok_ff &&
                      rd_rank_ff == IW'(ENTRIES - 1)) begin
                     old_ok_ff <= 1'b1; old_ff <= rd_idx_ff;
                  end
                  if (last_rd && !rd_vld_ff) state_ff <= ST_DEC;
               end
            end
            ST_DEC: begin
               idx_ff <= '0;
               rd_vld_ff <= 1'b0;
               state_ff <= ST_RSP;
               case (op_type'(req_ff.kind))
                  OP_INSERT: if (!zero_key && req_ff.value_length == psize_ff) begin
                     if (hit_ff) begin
                        mode_ff <= MODE_TOUCH; rref_ff <= hrank_ff; tgt_ff <= hit_idx_ff;
                        state_ff <= ST_UPD;
                     end else if (count_ff < CW'(ENTRIES) && free_ok_ff) begin
                        mode_ff <= MODE_AGE; tgt_ff <= free_ff; state_ff <= ST_UPD;
                     end else if (count_ff >= CW'(ENTRIES) && old_ok_ff) begin
                        // The oldest entry drops out before the ranks age.
                        valid_ff[old_ff] <= 1'b0;
                        count_ff <= count_ff - 1'b1;
                        mode_ff <= MODE_AGE; tgt_ff <= old_ff; state_ff <= ST_UPD;
                     end
                  end
                  OP_LOOKUP: if (!zero_key && hit_ff) begin
                     found_ff <= 1'b1; vout_ff <= hpay_ff;
                     mode_ff <= MODE_TOUCH; rref_ff <= hrank_ff; tgt_ff <= hit_idx_ff;
                     state_ff <= ST_UPD;
                  end
                  OP_EVICT: if (hit_ff) begin
                     valid_ff[hit_idx_ff] <= 1'b0;
                     count_ff <= count_ff - 1'b1;
                     mode_ff <= MODE_EVICT; rref_ff <= hrank_ff;
                     state_ff <= ST_UPD;
                  end
                  default: ;
               endcase
            end
            ST_UPD: begin
               if (!last_rd) idx_ff <= idx_ff + 1'b1;
               rd_vld_ff <= !last_rd;
               if (last_rd && !rd_vld_ff)
                  state_ff <= (mode_ff == MODE_EVICT) ? ST_RSP : ST_WR;
            end
            ST_WR: begin
               if (mode_ff == MODE_AGE) begin
                  valid_ff[tgt_ff] <= 1'b1;
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_RSP;
            end
            ST_RSP: if (rsp.ready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES)) else $error("entry count above capacity");
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(valid_ff) == int'(count_ff))
      else $error("entry count differs from valid marks");
   a_found_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.found |-> op_type'(req_ff.kind) == OP_LOOKUP)
      else $error("hit reported for a request that is no lookup");
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && op_type'(req_ff.kind) == OP_CLEAR |-> count_ff == '0)
      else $error("clear left entries");
endmodule
`default_nettype wire

@@ tb/lkvc_checker.sv @@
// Checker for the LRU key/value cache: watches the request and response channels,
// keeps its own copy of the cache state and compares every response. Depends on lkvc_pkg.
`default_nettype none
module lkvc_checker import lkvc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire req_type req_data,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic rsp_found,
   input  wire logic [63:0] rsp_value_out,
   input  wire logic [6:0] rsp_entries_used,
   output int fail_count,
   output int pending_count
);
   localparam int N = ENTRIES_DEF;

   typedef struct packed {
      logic       found;
      logic [63:0] value;
      logic [6:0] used;
   } answer_type;

   logic [31:0] tag_hi [N];
   logic [63:0] tag_mid [N];
   logic [63:0] tag_lo [N];
   logic [63:0] payload [N];
   logic        live [N];
   int          rank [N];
   int          used_count;
   logic [15:0] size_reg;
   answer_type  expected_answers [$];

   function automatic int find_entry(logic [31:0] hi, logic [63:0] mid, logic [63:0] lo);
      for (int i = 0; i < N; i++)
         if (live[i] && tag_hi[i] == hi && tag_mid[i] == mid && tag_lo[i] == lo)
            return i;
      return -1;
   endfunction

   function automatic void make_recent(int e);
      int r;
      r = rank[e];
      for (int i = 0; i < N; i++)
         if (live[i] && rank[i] < r) rank[i]++;
      rank[e] = 0;
   endfunction

   function automatic answer_type predict_answer(req_type q);
      answer_type a;
      int e;
      int slot;
      int r;
      logic zero_key;
      a = '0;
      slot = -1;
      zero_key = (q.key_hi == 0 && q.key_mid == 0 && q.key_lo == 0);
      case (op_type'(q.kind))
         OP_INSERT: begin
            if (!zero_key && q.value_length == size_reg) begin
               e = find_entry(q.key_hi, q.key_mid, q.key_lo);
               if (e >= 0) begin
                  make_recent(e);
               end else begin
                  if (used_count < N) begin
                     for (int i = 0; i < N && slot < 0; i++)
                        if (!live[i]) slot = i;
                  end else begin
                     for (int i = 0; i < N && slot < 0; i++)
                        if (live[i] && rank[i] == N - 1) slot = i;
                     if (slot >= 0) begin
                        live[slot] = 1'b0;
                        used_count--;
                     end
                  end
                  if (slot >= 0) begin
                     for (int i = 0; i < N; i++)
                        if (live[i]) rank[i]++;
                     tag_hi[slot] = q.key_hi;
                     tag_mid[slot] = q.key_mid;
                     tag_lo[slot] = q.key_lo;
                     payload[slot] = q.value_in;
                     rank[slot] = 0;
                     live[slot] = 1'b1;
                     used_count++;
                  end
               end
            end
         end
         OP_LOOKUP: begin
            if (!zero_key) begin
               e = find_entry(q.key_hi, q.key_mid, q.key_lo);
               if (e >= 0) begin
                  a.found = 1'b1;
                  a.value = payload[e];
                  make_recent(e);
               end
            end
         end
         OP_EVICT: begin
            e = find_entry(q.key_hi, q.key_mid, q.key_lo);
            if (e >= 0) begin
               r = rank[e];
               live[e] = 1'b0;
               used_count--;
               for (int i = 0; i < N; i++)
                  if (live[i] && rank[i] > r) rank[i]--;
            end
         end
         default: begin
            for (int i = 0; i < N; i++) live[i] = 1'b0;
            used_count = 0;
         end
      endcase
      a.used = 7'(used_count);
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            live[i] = 1'b0;
            rank[i] = 0;
         end
         used_count = 0;
         size_reg = PAYLOAD_SIZE_RST;
         expected_answers.delete();
         fail_count = 0;
      end else begin
         if (csr_we) size_reg = csr_wdata;
         if (req_valid && req_ready) expected_answers.push_back(predict_answer(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_entries_used), 64'd0);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", 64'(rsp_found), 64'(want.found));
               if (rsp_value_out !== want.value)
                  report_mismatch("value_out", rsp_value_out, want.value);
               if (rsp_entries_used !== want.used)
                  report_mismatch("entries_used", 64'(rsp_entries_used), 64'(want.used));
            end
         end
      end
      pending_count = expected_answers.size();
   end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Top of the LRU key/value cache testbench: clock, reset, request stimulus, idling and
// the verdict. Depends on lkvc_pkg, the channel interfaces, the cache and lkvc_checker.
`default_nettype none
module tb;
   import lkvc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic [15:0] size_now = PAYLOAD_SIZE_RST;
   logic [31:0] pool_hi [16];
   logic [63:0] pool_mid [16];
   logic [63:0] pool_lo [16];

   lkvc_req_if req ();
   lkvc_rsp_if rsp ();

   lru_key_value_cache i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   lkvc_checker i_checker (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_data({req.kind, req.key_hi, req.key_mid, req.key_lo, req.value_in,
                 req.value_length}),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_found(rsp.found),
      .rsp_value_out(rsp.value_out), .rsp_entries_used(rsp.entries_used),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.kind = OP_INSERT;
      req.key_hi = '0;
      req.key_mid = '0;
      req.key_lo = '0;
      req.value_in = '0;
      req.value_length = '0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock)
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

   // Drives one request and holds it until it is taken, idling beforehand at random.
   // Valid stays high after the handshake until the next idle cycle or a drain.
   task automatic send_request(op_type op, logic [31:0] hi, logic [63:0] mid,
                               logic [63:0] lo, logic [63:0] val, logic [15:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= op;
      req.key_hi <= hi;
      req.key_mid <= mid;
      req.key_lo <= lo;
      req.value_in <= val;
      req.value_length <= len;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_size(logic [15:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      size_now = v;
      @(posedge clock);
   endtask

   // Random request drawn mostly from a small key pool so that hits, refreshes and
   // replacement of the least recent entry are all reached.
   task automatic random_request(int pool_span);
      int p;
      int sel;
      op_type op;
      logic [15:0] len;
      p = $urandom_range(pool_span - 1);
      sel = $urandom_range(99);
      if (sel < 45) op = OP_INSERT;
      else if (sel < 80) op = OP_LOOKUP;
      else if (sel < 98) op = OP_EVICT;
      else op = OP_CLEAR;
      len = ($urandom_range(9) == 0) ? 16'($urandom) : size_now;
      if ($urandom_range(19) == 0)
         send_request(op, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, len);
      else
         send_request(op, pool_hi[p % 16] ^ 32'(p), pool_mid[p % 16], pool_lo[p % 16] + 64'(p),
                      {$urandom, $urandom}, len);
   endtask

   initial begin
      for (int i = 0; i < 16; i++) begin
         pool_hi[i] = $urandom;
         pool_mid[i] = {$urandom, $urandom};
         pool_lo[i] = {$urandom, $urandom};
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of the keys, zero keys, wrong lengths, refresh and clear.
      send_request(OP_INSERT, '1, '1, '1, '1, PAYLOAD_SIZE_RST);
      send_request(OP_LOOKUP, '1, '1, '1, '0, '0);
      send_request(OP_INSERT, '0, '0, '0, 64'h5, PAYLOAD_SIZE_RST);
      send_request(OP_LOOKUP, '0, '0, '0, '0, '0);
      send_request(OP_EVICT, '0, '0, '0, '0, '0);
      send_request(OP_INSERT, 32'h1, '0, '0, 64'hA5, PAYLOAD_SIZE_RST + 16'd1);
      send_request(OP_INSERT, '0, '0, 64'h1, 64'hDEAD, PAYLOAD_SIZE_RST);
      send_request(OP_INSERT, '0, '0, 64'h1, 64'hBEEF, PAYLOAD_SIZE_RST);
      send_request(OP_LOOKUP, '0, '0, 64'h1, '0, '0);
      send_request(OP_EVICT, '1, '1, '1, '0, '0);
      send_request(OP_EVICT, '1, '1, '1, '0, '0);
      send_request(OP_CLEAR, '1, '1, '1, '1, '1);
      send_request(OP_LOOKUP, '0, '0, 64'h1, '0, '0);

      set_size(16'd0);
      send_request(OP_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, '0, '1, 16'd0);
      send_request(OP_INSERT, 32'h2, '0, '0, '1, 16'hFFFF);
      // Overfill the cache so the least recent entry is replaced.
      for (int i = 1; i <= 70; i++)
         send_request(OP_INSERT, 32'(i), 64'(i), 64'(i), 64'(i * 3), 16'd0);
      send_request(OP_LOOKUP, 32'h8000_0000, 64'h8000_0000_0000_0000, '0, '0, '0);
      send_request(OP_LOOKUP, 32'd70, 64'd70, 64'd70, '0, '0);
      set_size(16'hFFFF);
      send_request(OP_INSERT, 32'h3, 64'h3, 64'h3, '0, 16'hFFFF);
      send_request(OP_LOOKUP, 32'h3, 64'h3, 64'h3, '0, '0);

      // Random phases through the idling patterns and register settings.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         set_size(ph == 3 ? PAYLOAD_SIZE_RST : 16'($urandom_range(65535)));
         for (int i = 0; i < 170; i++)
            random_request(ph[0] ? 16 : 90);
      end

      wait_drained();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
hdl/lkvc_pkg.sv
hdl/lkvc_req_if.sv
hdl/lkvc_rsp_if.sv
hdl/lru_key_value_cache.sv
tb/lkvc_checker.sv
tb/tb.sv
